[src/crmad_pkg.sv]
// Package for the clipped range mean absolute difference unit.
// Holds widths, constants, payload and queue entry types and a shared helper.
// Depends on nothing; every other file of the block imports it.
`timescale 1ns / 1ps

package crmad_pkg;

  localparam int MAX_BEAMS    = 1024;
  localparam int RANGE_W      = 16;
  localparam int FRAC_W       = 8;
  localparam int MEAN_W       = 24;
  localparam int CNT_W        = $clog2(MAX_BEAMS + 1);
  localparam int SUM_W        = RANGE_W + CNT_W;
  localparam int DIVD_W       = SUM_W + FRAC_W;
  localparam int ITER_W       = $clog2(DIVD_W);
  localparam int QUEUE_DEPTH  = 2;
  localparam int QPTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

  localparam logic [RANGE_W-1:0] CUTOFF_RESET = RANGE_W'(10000);

  typedef struct packed {
    logic [RANGE_W-1:0] range_mm;
    logic               is_last;
  } in_item_t;

  typedef struct packed {
    logic [MEAN_W-1:0] mean_difference;
    logic              beam_overflow;
  } out_item_t;

  typedef struct packed {
    logic [SUM_W-1:0]   diff_sum;
    logic [RANGE_W-1:0] prev_clipped;
    logic [RANGE_W-1:0] first_clipped;
    logic [CNT_W-1:0]   beam_count;
    logic               overflow_seen;
  } scan_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  function automatic logic [RANGE_W-1:0] abs_diff(input logic [RANGE_W-1:0] a,
                                                  input logic [RANGE_W-1:0] b);
    abs_diff = (a > b) ? (a - b) : (b - a);
  endfunction

endpackage

[src/crmad_front.sv]
// Front part: clips each range, accumulates the scan and hands closed scans on.
// Depends on crmad_pkg; feeds crmad_queue.
`timescale 1ns / 1ps

module crmad_front (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [15:0]              cfg_wdata_i,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  crmad_pkg::in_item_t      in_data_i,
  input  crmad_pkg::queue_status_t q_status_i,
  output logic                     push_o,
  output crmad_pkg::scan_entry_t   push_entry_o
);
  import crmad_pkg::*;

  logic [RANGE_W-1:0] cutoff_q;
  logic [RANGE_W-1:0] first_q, first_d;
  logic [RANGE_W-1:0] prev_q, prev_d;
  logic [SUM_W-1:0]   sum_q, sum_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic               ovf_q, ovf_d;
  logic [RANGE_W-1:0] clipped;
  logic               accept;

  assign in_stall_o = q_status_i.full;
  assign accept     = in_valid_i && !in_stall_o;
  assign clipped    = (in_data_i.range_mm > cutoff_q) ? cutoff_q : in_data_i.range_mm;

  always_comb begin
    first_d = first_q;
    prev_d  = prev_q;
    sum_d   = sum_q;
    count_d = count_q;
    ovf_d   = ovf_q;
    if (count_q == '0) begin
      first_d = clipped;
      prev_d  = clipped;
      count_d = CNT_W'(1);
    end else if (count_q < CNT_W'(MAX_BEAMS)) begin
      sum_d   = sum_q + SUM_W'(abs_diff(clipped, prev_q));
      prev_d  = clipped;
      count_d = count_q + CNT_W'(1);
    end else begin
      ovf_d = 1'b1;
    end
  end

  assign push_o                     = accept && in_data_i.is_last;
  assign push_entry_o.diff_sum      = sum_d;
  assign push_entry_o.prev_clipped  = prev_d;
  assign push_entry_o.first_clipped = first_d;
  assign push_entry_o.beam_count    = count_d;
  assign push_entry_o.overflow_seen = ovf_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cutoff_q <= CUTOFF_RESET;
      first_q  <= '0;
      prev_q   <= '0;
      sum_q    <= '0;
      count_q  <= '0;
      ovf_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cutoff_q <= cfg_wdata_i;
      end
      if (accept) begin
        if (in_data_i.is_last) begin
          first_q <= '0;
          prev_q  <= '0;
          sum_q   <= '0;
          count_q <= '0;
          ovf_q   <= 1'b0;
        end else begin
          first_q <= first_d;
          prev_q  <= prev_d;
          sum_q   <= sum_d;
          count_q <= count_d;
          ovf_q   <= ovf_d;
        end
      end
    end
  end

endmodule

[src/crmad_queue.sv]
// Short queue of closed scans between the front and the back part.
// Depends on crmad_pkg.
`timescale 1ns / 1ps

module crmad_queue (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     push_i,
  input  crmad_pkg::scan_entry_t   push_entry_i,
  input  logic                     pop_i,
  output crmad_pkg::scan_entry_t   head_o,
  output crmad_pkg::queue_status_t status_o
);
  import crmad_pkg::*;

  scan_entry_t         slots_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_q;
  logic [QPTR_W-1:0]   rd_ptr_q;
  logic [QCNT_W-1:0]   fill_q;
  logic                do_push;
  logic                do_pop;

  assign status_o.full  = (fill_q == QCNT_W'(QUEUE_DEPTH));
  assign status_o.empty = (fill_q == '0);
  assign do_push        = push_i && !status_o.full;
  assign do_pop         = pop_i && !status_o.empty;
  assign head_o         = slots_q[rd_ptr_q];

  function automatic logic [QPTR_W-1:0] next_ptr(input logic [QPTR_W-1:0] p);
    next_ptr = (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
  endfunction

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slots_q[wr_ptr_q] <= push_entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= next_ptr(wr_ptr_q);
      end
      if (do_pop) begin
        rd_ptr_q <= next_ptr(rd_ptr_q);
      end
      if (do_push && !do_pop) begin
        fill_q <= fill_q + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        fill_q <= fill_q - QCNT_W'(1);
      end
    end
  end

endmodule

[src/crmad_back.sv]
// Back part: closes the ring, divides the sum by the beam count bit by bit,
// saturates and holds the result in the output register. Depends on crmad_pkg.
`timescale 1ns / 1ps

module crmad_back (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  crmad_pkg::scan_entry_t   head_i,
  input  crmad_pkg::queue_status_t q_status_i,
  output logic                     pop_o,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output crmad_pkg::out_item_t     out_data_o
);
  import crmad_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CLOSE,
    S_DIV,
    S_OUT
  } state_e;

  state_e             state_q;
  scan_entry_t        job_q;
  logic [DIVD_W-1:0]  dvd_q;
  logic [CNT_W-1:0]   rem_q;
  logic [ITER_W-1:0]  iter_q;
  logic               out_valid_q;
  out_item_t          out_q;
  logic [CNT_W:0]     rem_shift;
  logic               q_bit;
  logic [CNT_W:0]     rem_sub;
  logic [SUM_W-1:0]   closed_sum;
  logic [MEAN_W-1:0]  mean_sat;
  logic               out_free;

  assign pop_o       = (state_q == S_IDLE) && !q_status_i.empty;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign out_free    = !out_valid_q || !out_stall_i;

  assign closed_sum = job_q.diff_sum + SUM_W'(abs_diff(job_q.prev_clipped,
                                                       job_q.first_clipped));
  assign rem_shift  = {rem_q, dvd_q[DIVD_W-1]};
  assign q_bit      = (rem_shift >= {1'b0, job_q.beam_count});
  assign rem_sub    = rem_shift - {1'b0, job_q.beam_count};
  assign mean_sat   = (|dvd_q[DIVD_W-1:MEAN_W]) ? '1 : dvd_q[MEAN_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      job_q       <= '0;
      dvd_q       <= '0;
      rem_q       <= '0;
      iter_q      <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      if ((state_q == S_OUT) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (pop_o) begin
            job_q   <= head_i;
            state_q <= S_CLOSE;
          end
        end
        S_CLOSE: begin
          dvd_q   <= {closed_sum, {FRAC_W{1'b0}}};
          rem_q   <= '0;
          iter_q  <= '0;
          state_q <= S_DIV;
        end
        S_DIV: begin
          rem_q  <= q_bit ? rem_sub[CNT_W-1:0] : rem_shift[CNT_W-1:0];
          dvd_q  <= {dvd_q[DIVD_W-2:0], q_bit};
          iter_q <= iter_q + ITER_W'(1);
          if (iter_q == ITER_W'(DIVD_W - 1)) begin
            state_q <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_free) begin
            out_q.mean_difference <= mean_sat;
            out_q.beam_overflow   <= job_q.overflow_seen;
            state_q               <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

[src/clipped_range_mean_abs_difference_unit.sv]
// Top level of the clipped range mean absolute difference unit.
// Depends on crmad_pkg, crmad_front, crmad_queue and crmad_back.
//
//   channel  direction  handshake              payload
//   cfg      in         cfg_we_i               cfg_wdata_i (range cutoff, mm)
//   in       in         in_valid_i/in_stall_o  in_data_i (range_mm, is_last)
//   out      out        out_valid_o/out_stall_i out_data_o (mean_difference, beam_overflow)
//
// Range samples are taken one per cycle while the queue has room.
// In the back part a closed scan passes the close, divide and output states in turn;
// the restoring divider yields one quotient bit per cycle.
// Up to two closed scans wait in the queue; in_stall_o rises only while it is full.
// Reset clears all scan state and sets the cutoff to 10000 mm.
`timescale 1ns / 1ps

module clipped_range_mean_abs_difference_unit (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [15:0]           cfg_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  crmad_pkg::in_item_t   in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output crmad_pkg::out_item_t  out_data_o
);
  import crmad_pkg::*;

  logic          push;
  scan_entry_t   push_entry;
  logic          pop;
  scan_entry_t   head;
  queue_status_t q_status;

  crmad_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_data_i    (in_data_i),
    .q_status_i   (q_status),
    .push_o       (push),
    .push_entry_o (push_entry)
  );

  crmad_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_entry_i (push_entry),
    .pop_i        (pop),
    .head_o       (head),
    .status_o     (q_status)
  );

  crmad_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .q_status_i  (q_status),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

[tb/tb_top.sv]
// Self-checking testbench for clipped_range_mean_abs_difference_unit.
// Drives scans of range samples and cutoff writes, predicts each scan mean in
// its own scan model, and checks every result transfer. Depends on crmad_pkg.
`timescale 1ns / 1ps

module tb_top;
  import crmad_pkg::*;

  localparam int HOLD_CYCLES    = 700;
  localparam int SETTLE_CYCLES  = 2 * (DIVD_W + 3);
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int RANDOM_BEAMS   = 120;
  localparam int SEGMENTS       = 6;
  localparam int MAX_REPORTS    = 10;

  typedef enum logic {ROW_BEAM, ROW_CUTOFF} row_kind_e;

  typedef struct packed {
    row_kind_e          kind;
    logic [RANGE_W-1:0] value;
    logic               last;
    logic               known;
    logic [MEAN_W-1:0]  mean;
    logic               ovf;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we = 1'b0;
  logic [15:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;

  logic [RANGE_W-1:0] model_cutoff;
  logic [RANGE_W-1:0] ring_first;
  logic [RANGE_W-1:0] ring_prev;
  logic [SUM_W-1:0]   ring_sum;
  logic [CNT_W-1:0]   ring_beams;
  logic               ring_overflow;

  out_item_t pending_means[$];
  logic [RANGE_W-1:0] recent_range = '0;
  int burst_left = 0;
  int fault_count = 0;
  int beams_sent = 0;
  int scans_closed = 0;
  int overflow_scans = 0;
  int results_checked = 0;
  int cutoff_writes = 0;
  bit hold_request = 1'b0;
  bit hold_active = 1'b0;
  bit hold_done = 1'b0;

  stim_row_t directed_rows [0:28] = '{
    '{ROW_BEAM,   16'd0,     1'b1, 1'b1, 24'd0,        1'b0},
    '{ROW_BEAM,   16'd65535, 1'b1, 1'b1, 24'd0,        1'b0},
    '{ROW_BEAM,   16'd0,     1'b0, 1'b0, 24'd0,        1'b0},
    '{ROW_BEAM,   16'd20000, 1'b1, 1'b0, 24'd0,        1'b0},
    '{ROW_BEAM,   16'd100,   1'b0, 1'b0, 24'd0,        1'b0},
    '{ROW_BEAM,   16'd200,   1'b0, 1'b0, 24'd0,        1'b0},
    '{ROW_BEAM,   16'd300,   1'b1, 1'b0, 24'd0,        1'b0},
    '{ROW_BEAM,   16'd5000,  1'b0, 1'b0, 24'd0,        1'b0},
    '{ROW_BEAM,   16'd5000,  1'b0, 1'b0, 24'd0,        1'b0},
    '{ROW_BEAM,   16'd5000,  1'b1, 1'b1, 24'd0,        1'b0},
    '{ROW_BEAM,   16'd65535, 1'b0, 1'b0, 24'd0,        1'b0},
    '{ROW_BEAM,   16'd65535, 1'b1, 1'b1, 24'd0,        1'b0},
    '{ROW_BEAM,   16'd0,     1'b0, 1'b0, 24'd0,        1'b0},
    '{ROW_BEAM,   16'd65535, 1'b0, 1'b0, 24'd0,        1'b0},
    '{ROW_BEAM,   16'd0,     1'b0, 1'b0, 24'd0,        1'b0},
    '{ROW_BEAM,   16'd65535, 1'b1, 1'b0, 24'd0,        1'b0},
    '{ROW_CUTOFF, 16'd65535, 1'b0, 1'b0, 24'd0,        1'b0},
    '{ROW_BEAM,   16'd0,     1'b0, 1'b0, 24'd0,        1'b0},
    '{ROW_BEAM,   16'd65535, 1'b1, 1'b1, 24'd16776960, 1'b0},
    '{ROW_BEAM,   16'd65535, 1'b1, 1'b1, 24'd0,        1'b0},
    '{ROW_CUTOFF, 16'd0,     1'b0, 1'b0, 24'd0,        1'b0},
    '{ROW_BEAM,   16'd65535, 1'b0, 1'b0, 24'd0,        1'b0},
    '{ROW_BEAM,   16'd12345, 1'b0, 1'b0, 24'd0,        1'b0},
    '{ROW_BEAM,   16'd1,     1'b1, 1'b1, 24'd0,        1'b0},
    '{ROW_CUTOFF, 16'd1000,  1'b0, 1'b0, 24'd0,        1'b0},
    '{ROW_BEAM,   16'd0,     1'b0, 1'b0, 24'd0,        1'b0},
    '{ROW_BEAM,   16'd3000,  1'b0, 1'b0, 24'd0,        1'b0},
    '{ROW_CUTOFF, 16'd50000, 1'b0, 1'b0, 24'd0,        1'b0},
    '{ROW_BEAM,   16'd3000,  1'b1, 1'b0, 24'd0,        1'b0}
  };

  clipped_range_mean_abs_difference_unit i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  always #4 clk = ~clk;

  task automatic clear_ring();
    ring_first = '0;
    ring_prev = '0;
    ring_sum = '0;
    ring_beams = '0;
    ring_overflow = 1'b0;
  endtask

  task automatic fold_beam(input logic [RANGE_W-1:0] beam_range, input logic last,
                           output bit closed, output out_item_t res);
    logic [RANGE_W-1:0] clipped;
    logic [DIVD_W-1:0] quotient;
    clipped = (beam_range > model_cutoff) ? model_cutoff : beam_range;
    closed = 1'b0;
    res = '0;
    if (ring_beams == 0) begin
      ring_first = clipped;
      ring_prev = clipped;
      ring_beams = CNT_W'(1);
    end else if (ring_beams < CNT_W'(MAX_BEAMS)) begin
      ring_sum += (clipped > ring_prev) ? (clipped - ring_prev) : (ring_prev - clipped);
      ring_prev = clipped;
      ring_beams++;
    end else begin
      ring_overflow = 1'b1;
    end
    if (last) begin
      ring_sum += (ring_prev > ring_first) ? (ring_prev - ring_first) : (ring_first - ring_prev);
      quotient = {ring_sum, FRAC_W'(0)} / DIVD_W'(ring_beams);
      res.mean_difference = (quotient > DIVD_W'({MEAN_W{1'b1}})) ? {MEAN_W{1'b1}}
                                                                  : quotient[MEAN_W-1:0];
      res.beam_overflow = ring_overflow;
      closed = 1'b1;
      scans_closed++;
      if (ring_overflow) overflow_scans++;
      clear_ring();
    end
  endtask

  task automatic send_beam(input logic [RANGE_W-1:0] beam_range, input logic last,
                           input logic known, input logic [MEAN_W-1:0] known_mean,
                           input logic known_ovf);
    int gap;
    bit closed;
    out_item_t res;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(80, 250) : $urandom_range(1, 30);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data <= '{range_mm: beam_range, is_last: last};
    do @(posedge clk); while (in_stall);
    beams_sent++;
    recent_range = beam_range;
    fold_beam(beam_range, last, closed, res);
    if (closed) begin
      if (known) begin
        res.mean_difference = known_mean;
        res.beam_overflow = known_ovf;
      end
      pending_means.push_back(res);
    end
  endtask

  task automatic settle_idle();
    in_valid <= 1'b0;
    while (pending_means.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_cutoff(input logic [RANGE_W-1:0] value);
    settle_idle();
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    model_cutoff = value;
    cutoff_writes++;
  endtask

  function automatic logic [RANGE_W-1:0] pick_range();
    int lo;
    int hi;
    int step;
    case ($urandom_range(0, 9))
      0, 1: pick_range = RANGE_W'($urandom);
      2: pick_range = RANGE_W'($urandom_range(0, 15));
      3: pick_range = RANGE_W'(65535 - $urandom_range(0, 15));
      4, 5: begin
        lo = (int'(model_cutoff) > 8) ? int'(model_cutoff) - 8 : 0;
        hi = (int'(model_cutoff) < 65527) ? int'(model_cutoff) + 8 : 65535;
        pick_range = RANGE_W'($urandom_range(hi, lo));
      end
      6: pick_range = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      default: begin
        step = $urandom_range(0, 600) - 300;
        lo = int'(recent_range) + step;
        pick_range = (lo < 0) ? '0 : (lo > 65535) ? 16'hFFFF : RANGE_W'(lo);
      end
    endcase
  endfunction

  task automatic report_fault(input string what, input int want, input int got);
    fault_count++;
    if (fault_count <= MAX_REPORTS)
      $display("[%0t] mismatch on %s: expected %0d, got %0d", $realtime, what, want, got);
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (rst_ni && out_valid && !out_stall) begin
      if (pending_means.size() == 0) begin
        report_fault("unexpected result (mean_difference)", -1, int'(out_data.mean_difference));
      end else begin
        want = pending_means.pop_front();
        results_checked++;
        if (out_data.mean_difference !== want.mean_difference)
          report_fault("mean_difference", int'(want.mean_difference),
                       int'(out_data.mean_difference));
        if (out_data.beam_overflow !== want.beam_overflow)
          report_fault("beam_overflow", int'(want.beam_overflow), int'(out_data.beam_overflow));
      end
    end
  end

  initial begin
    int mode;
    int span;
    int tick;
    wait (rst_ni);
    tick = 0;
    forever begin
      if (hold_request && !hold_done) begin
        hold_active = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end
      mode = $urandom_range(0, 3);
      span = $urandom_range(16, 160);
      repeat (span) begin
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= $urandom_range(0, 1);
          2: out_stall <= ($urandom_range(0, 7) == 0);
          default: out_stall <= ((tick % 7) < 3);
        endcase
        tick++;
        @(posedge clk);
      end
    end
  end

  initial begin
    int idle;
    idle = 0;
    while (idle < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
        idle = 0;
      else
        idle++;
    end
    $display("Watchdog expired after %0d cycles without a transfer.", WATCHDOG_LIMIT);
    $display("** clipped_range_mean_abs_difference_unit: FAILED **");
    $finish;
  end

  initial begin
    int seg;
    int len;
    int budget;
    int seg_beams;
    bit long_done;
    logic [RANGE_W-1:0] cut;
    model_cutoff = CUTOFF_RESET;
    clear_ring();
    long_done = 1'b0;
    repeat (5) @(posedge clk);
    rst_ni <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CUTOFF)
        write_cutoff(directed_rows[i].value);
      else
        send_beam(directed_rows[i].value, directed_rows[i].last, directed_rows[i].known,
                  directed_rows[i].mean, directed_rows[i].ovf);
    end

    budget = RANDOM_BEAMS / SEGMENTS;
    for (seg = 0; seg < SEGMENTS; seg++) begin
      case (seg)
        0: cut = CUTOFF_RESET;
        1: cut = 16'hFFFF;
        3: cut = '0;
        4: cut = RANGE_W'($urandom_range(1, 64));
        default: cut = RANGE_W'($urandom);
      endcase
      write_cutoff(cut);
      if (seg == 1) begin
        hold_request = 1'b1;
        wait (hold_active);
      end
      seg_beams = 0;
      while (seg_beams < budget) begin
        case ($urandom_range(0, 19))
          0, 1, 2, 3, 4, 5: len = $urandom_range(1, 3);
          19: len = $urandom_range(60, 160);
          default: len = $urandom_range(4, 24);
        endcase
        // Short scans during the output hold-off fill the queue quickly.
        if (seg == 1) len = $urandom_range(1, 3);
        if (seg == 2 && !long_done) begin
          len = MAX_BEAMS + $urandom_range(1, 24);
          long_done = 1'b1;
        end
        for (int k = 0; k < len; k++)
          send_beam(pick_range(), k == len - 1, 1'b0, '0, 1'b0);
        seg_beams += len;
      end
      // The next cutoff write then lands in the middle of an open scan.
      if (seg == 3) begin
        len = $urandom_range(1, 5);
        repeat (len) send_beam(pick_range(), 1'b0, 1'b0, '0, 1'b0);
      end
    end

    settle_idle();
    $display("Run covered %0d beams in %0d scans (%0d past the beam limit) over %0d cutoff writes.",
             beams_sent, scans_closed, overflow_scans, cutoff_writes);
    $display("Checked %0d result transfers, %0d faults, including a %0d-cycle output hold-off.",
             results_checked, fault_count, HOLD_CYCLES);
    if (fault_count == 0 && pending_means.size() == 0) begin
      $display("** clipped_range_mean_abs_difference_unit: PASSED **");
    end else begin
      $display("** clipped_range_mean_abs_difference_unit: FAILED **");
    end
    $finish;
  end

endmodule
